### src/rcfd_pkg.sv
// Shared types, constants and scaling functions for the RC frame decoder.
package rcfd_pkg;

   localparam int FRAME_LENGTH = 18;
   localparam int POS_WIDTH    = $clog2(FRAME_LENGTH + 1);
   localparam int IDX_WIDTH    = $clog2(FRAME_LENGTH);

   localparam logic [15:0] FRAME_GAP_RESET = 16'd100;

   // Channel scaling: floor((758 * x + 624242) / 1000)
   localparam int NUM_WIDTH = 26;
   localparam logic [9:0]  SCALE_MUL    = 10'd758;
   localparam logic [19:0] SCALE_OFFSET = 20'd624242;

   // Divide by 1000 as multiply by ceil(2^36 / 1000); exact for all 26-bit numerators
   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_WIDTH = 27;
   localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = 27'd68719477;
   localparam int PROD_WIDTH = NUM_WIDTH + RECIP_WIDTH;

   localparam logic [10:0] SWITCH_LOW  = 11'd400;
   localparam logic [10:0] SWITCH_MID1 = 11'd900;
   localparam logic [10:0] SWITCH_MID2 = 11'd1400;
   localparam logic [10:0] SWITCH_HIGH = 11'd1900;

   typedef struct packed {
      logic        valid;
      logic [10:0] ch0;
      logic [10:0] ch1;
      logic [10:0] ch2;
      logic [10:0] ch3;
      logic [1:0]  sw_a;
      logic [1:0]  sw_b;
      logic [15:0] ch6;
   } frame_beat_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] n0;
      logic [NUM_WIDTH-1:0] n1;
      logic [NUM_WIDTH-1:0] n2;
      logic [NUM_WIDTH-1:0] n3;
      logic [NUM_WIDTH-1:0] n6;
      logic [10:0]          sw_a;
      logic [10:0]          sw_b;
   } numer_type;

   function automatic logic [NUM_WIDTH-1:0] scale_numer(input logic [15:0] x);
      logic [NUM_WIDTH-1:0] prod;
      prod = NUM_WIDTH'(x) * NUM_WIDTH'(SCALE_MUL);
      return prod + NUM_WIDTH'(SCALE_OFFSET);
   endfunction

   function automatic logic [15:0] div_1000(input logic [NUM_WIDTH-1:0] n);
      logic [PROD_WIDTH-1:0] prod;
      prod = PROD_WIDTH'(n) * PROD_WIDTH'(RECIP_1000);
      return prod[RECIP_SHIFT +: 16];
   endfunction

   function automatic logic [10:0] switch_value(input logic [1:0] v);
      logic [10:0] res;
      case (v)
         2'd0:    res = SWITCH_LOW;
         2'd1:    res = SWITCH_MID1;
         2'd2:    res = SWITCH_MID2;
         default: res = SWITCH_HIGH;
      endcase
      return res;
   endfunction

endpackage

### src/rcfd_if.sv
// Channel interfaces of the RC frame decoder: byte input, result output, gap register write.
interface rcfd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] arrival_time_us;
   modport source (output valid, rx_byte, arrival_time_us, input ready);
   modport sink   (input valid, rx_byte, arrival_time_us, output ready);
endinterface

interface rcfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] stick_ch0;
   logic [11:0] stick_ch1;
   logic [11:0] stick_ch2;
   logic [11:0] stick_ch3;
   logic [10:0] switch_a;
   logic [10:0] switch_b;
   logic [15:0] wheel_ch6;
   modport source (output valid, stick_ch0, stick_ch1, stick_ch2, stick_ch3,
                   switch_a, switch_b, wheel_ch6, input ready);
   modport sink   (input valid, stick_ch0, stick_ch1, stick_ch2, stick_ch3,
                   switch_a, switch_b, wheel_ch6, output ready);
endinterface

interface rcfd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_gap_us;
   modport source (output valid, frame_gap_us, input ready);
   modport sink   (input valid, frame_gap_us, output ready);
endinterface

### src/rcfd_frame_collect.sv
// Frame sync and byte collection; registers the raw channel fields of a complete frame.
module rcfd_frame_collect (
   input  logic                    clock,
   input  logic                    reset,
   rcfd_req_if.sink                req_bus,
   input  logic [15:0]             frame_gap_us,
   input  logic                    raw_ready,
   output rcfd_pkg::frame_beat_type raw_beat
);
   import rcfd_pkg::*;

   logic [7:0]           frame_bytes_ff [FRAME_LENGTH];
   logic [POS_WIDTH-1:0] byte_pos_ff, byte_pos_in;
   logic [31:0]          prev_time_ff, prev_time_in;
   frame_beat_type       raw_ff, raw_in;

   logic                 accept;
   logic                 raw_free;
   logic [31:0]          elapsed;
   logic                 gap;
   logic [POS_WIDTH-1:0] pos_eff;
   logic                 store;
   logic                 complete;

   assign raw_free      = !raw_ff.valid || raw_ready;
   assign req_bus.ready = raw_free;
   assign accept        = req_bus.valid && raw_free;

   assign elapsed  = req_bus.arrival_time_us - prev_time_ff;
   assign gap      = elapsed >= {16'd0, frame_gap_us};
   assign pos_eff  = gap ? '0 : byte_pos_ff;
   // a frame only starts on a gap; a full frame ignores bytes until the next gap
   assign store    = accept && (gap || (byte_pos_ff != '0)) &&
                     (pos_eff < POS_WIDTH'(FRAME_LENGTH));
   assign complete = store && (pos_eff == POS_WIDTH'(FRAME_LENGTH - 1));

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      prev_time_in = prev_time_ff;
      if (accept) begin
         prev_time_in = req_bus.arrival_time_us;
         if (store) begin
            byte_pos_in = pos_eff + POS_WIDTH'(1);
         end
      end
   end

   always_comb begin
      raw_in = raw_ff;
      if (raw_free) begin
         raw_in.valid = complete;
         raw_in.ch0   = {frame_bytes_ff[1][2:0], frame_bytes_ff[0]};
         raw_in.ch1   = {frame_bytes_ff[2][5:0], frame_bytes_ff[1][7:3]};
         raw_in.ch2   = {frame_bytes_ff[4][0], frame_bytes_ff[3], frame_bytes_ff[2][7:6]};
         raw_in.ch3   = {frame_bytes_ff[5][3:0], frame_bytes_ff[4][7:1]};
         raw_in.sw_a  = frame_bytes_ff[5][7:6];
         raw_in.sw_b  = frame_bytes_ff[5][5:4];
         // last byte comes straight from the input beat
         raw_in.ch6   = {req_bus.rx_byte, frame_bytes_ff[FRAME_LENGTH-2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         prev_time_ff <= '0;
         raw_ff       <= '0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         prev_time_ff <= prev_time_in;
         raw_ff       <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         frame_bytes_ff[pos_eff[IDX_WIDTH-1:0]] <= req_bus.rx_byte;
      end
   end

   assign raw_beat = raw_ff;

endmodule

### src/rcfd_scale.sv
// Two-stage channel scaling: numerator multiply-add, then divide by 1000 into the result register.
module rcfd_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  rcfd_pkg::frame_beat_type raw_beat,
   output logic                     raw_ready,
   rcfd_rsp_if.source               rsp_bus
);
   import rcfd_pkg::*;

   logic      numer_valid_ff, numer_valid_in;
   numer_type numer_ff, numer_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [11:0] ch0_ff, ch1_ff, ch2_ff, ch3_ff;
   logic [10:0] sw_a_ff, sw_b_ff;
   logic [15:0] ch6_ff;

   logic out_free;
   logic numer_free;
   logic [15:0] q0, q1, q2, q3, q6;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign numer_free = !numer_valid_ff || out_free;
   assign raw_ready  = numer_free;

   always_comb begin
      numer_valid_in = numer_valid_ff;
      numer_in       = numer_ff;
      if (numer_free) begin
         numer_valid_in = raw_beat.valid;
         numer_in.n0    = scale_numer({5'd0, raw_beat.ch0});
         numer_in.n1    = scale_numer({5'd0, raw_beat.ch1});
         numer_in.n2    = scale_numer({5'd0, raw_beat.ch2});
         numer_in.n3    = scale_numer({5'd0, raw_beat.ch3});
         numer_in.n6    = scale_numer(raw_beat.ch6);
         numer_in.sw_a  = switch_value(raw_beat.sw_a);
         numer_in.sw_b  = switch_value(raw_beat.sw_b);
      end
   end

   assign q0 = div_1000(numer_ff.n0);
   assign q1 = div_1000(numer_ff.n1);
   assign q2 = div_1000(numer_ff.n2);
   assign q3 = div_1000(numer_ff.n3);
   assign q6 = div_1000(numer_ff.n6);

   assign rsp_valid_in = out_free ? numer_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         numer_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         numer_valid_ff <= numer_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      numer_ff <= numer_in;
      // hold the result while the receiver stalls
      if (out_free) begin
         ch0_ff  <= q0[11:0];
         ch1_ff  <= q1[11:0];
         ch2_ff  <= q2[11:0];
         ch3_ff  <= q3[11:0];
         sw_a_ff <= numer_ff.sw_a;
         sw_b_ff <= numer_ff.sw_b;
         ch6_ff  <= q6;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.stick_ch0 = ch0_ff;
   assign rsp_bus.stick_ch1 = ch1_ff;
   assign rsp_bus.stick_ch2 = ch2_ff;
   assign rsp_bus.stick_ch3 = ch3_ff;
   assign rsp_bus.switch_a  = sw_a_ff;
   assign rsp_bus.switch_b  = sw_b_ff;
   assign rsp_bus.wheel_ch6 = ch6_ff;

endmodule

### src/rc_frame_channel_decoder_core.sv
// Top level of the RC frame decoder: gap register, frame collection and channel scaling.
//
// Usage:
//   req_bus  - one beat per received serial byte with its microsecond timestamp.
//              A byte at least frame_gap_us after the previous one starts a frame;
//              bytes before the first gap and after a full 18-byte frame are dropped.
//   rsp_bus  - one beat per complete frame carrying four scaled sticks, two
//              switches and the scaled wheel value.
//   csr_bus  - writes frame_gap_us; always ready, write only while idle.
// Result path: after the beat of a frame's last byte the field, numerator and
//   result registers load in turn; rsp_bus.valid rises as the result register loads.
// Throughput: one byte per cycle while req_bus.ready is high, each byte updating the
//   frame state as it arrives; an unstalled scaling stage takes a new frame every cycle.
// Reset: clears the byte position, the previous timestamp (gap measured from
//   time zero) and all stage valids; frame_gap_us returns to 100.
// Stall: a result held on rsp_bus backs up the scaling stages; req_bus.ready
//   drops only when the raw field register is full and cannot advance.
module rc_frame_channel_decoder_core (
   input  logic       clock,
   input  logic       reset,
   rcfd_req_if.sink   req_bus,
   rcfd_rsp_if.source rsp_bus,
   rcfd_csr_if.sink   csr_bus
);
   import rcfd_pkg::*;

   logic [15:0]    frame_gap_ff, frame_gap_in;
   frame_beat_type raw_beat;
   logic           raw_ready;

   assign csr_bus.ready = 1'b1;
   assign frame_gap_in  = csr_bus.valid ? csr_bus.frame_gap_us : frame_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_gap_ff <= FRAME_GAP_RESET;
      end else begin
         frame_gap_ff <= frame_gap_in;
      end
   end

   rcfd_frame_collect u_collect (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .frame_gap_us (frame_gap_ff),
      .raw_ready    (raw_ready),
      .raw_beat     (raw_beat)
   );

   rcfd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .raw_beat  (raw_beat),
      .raw_ready (raw_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

### src/rcfd_checker.sv
// Port-level checks of the RC frame decoder, bound to the top level.
module rcfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] switch_a,
   input logic [10:0] switch_b
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a fresh result follows a byte beat through the three stages
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_beat, 3))
      else $error("result without a byte beat three cycles earlier");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (switch_a == 11'd400 || switch_a == 11'd900 ||
                     switch_a == 11'd1400 || switch_a == 11'd1900) &&
                    (switch_b == 11'd400 || switch_b == 11'd900 ||
                     switch_b == 11'd1400 || switch_b == 11'd1900))
      else $error("switch value off its four levels");

endmodule

bind rc_frame_channel_decoder_core rcfd_checker u_rcfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .switch_a  (rsp_bus.switch_a),
   .switch_b  (rsp_bus.switch_b)
);

### test/tb_rc_frame_channel_decoder_core.sv
// Testbench for the RC frame decoder: random framed byte streams checked against a frame predictor.
module tb_rc_frame_channel_decoder_core;
   import rcfd_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_BYTES    = 185;

   typedef struct packed {
      logic [11:0] ch0;
      logic [11:0] ch1;
      logic [11:0] ch2;
      logic [11:0] ch3;
      logic [10:0] sw_a;
      logic [10:0] sw_b;
      logic [15:0] ch6;
   } rc_channels_type;

   class channel_scoreboard;
      logic [15:0]     gap_us;
      logic [31:0]     last_time;
      int unsigned     fill;
      logic [7:0]      frame_buf[FRAME_LENGTH];
      rc_channels_type pending_frames[$];
      int unsigned     error_count;

      function new();
         gap_us      = FRAME_GAP_RESET;
         last_time   = '0;
         fill        = 0;
         error_count = 0;
      endfunction

      function void set_gap(input logic [15:0] v);
         gap_us = v;
      endfunction

      function int unsigned pending();
         return pending_frames.size();
      endfunction

      function logic [15:0] scaled(input int unsigned x);
         longint unsigned n;
         n = 64'd758 * x + 64'd624242;
         return 16'(n / 1000);
      endfunction

      // Track one accepted byte; return 1 when it lands in the frame buffer.
      function bit note_byte(input logic [7:0] b, input logic [31:0] t);
         logic [31:0]     diff;
         bit              gap;
         logic [15:0]     w01, w45;
         logic [23:0]     w234;
         rc_channels_type exp_frame;
         diff = t - last_time;
         gap = diff >= {16'd0, gap_us};
         last_time = t;
         if (gap) fill = 0;
         if (fill == 0 && !gap) return 0;
         if (fill >= FRAME_LENGTH) return 0;
         frame_buf[fill] = b;
         fill++;
         if (fill == FRAME_LENGTH) begin
            w01  = {frame_buf[1], frame_buf[0]};
            w234 = {frame_buf[4], frame_buf[3], frame_buf[2]};
            w45  = {frame_buf[5], frame_buf[4]};
            exp_frame.ch0  = 12'(scaled(w01[10:0]));
            exp_frame.ch1  = 12'(scaled({frame_buf[2], frame_buf[1]} >> 3 & 16'h07FF));
            exp_frame.ch2  = 12'(scaled(w234[16:6]));
            exp_frame.ch3  = 12'(scaled(w45[11:1]));
            exp_frame.sw_a = 11'(500 * frame_buf[5][7:6] + 400);
            exp_frame.sw_b = 11'(500 * frame_buf[5][5:4] + 400);
            exp_frame.ch6  = scaled({frame_buf[17], frame_buf[16]});
            pending_frames.push_back(exp_frame);
         end
         return 1;
      endfunction

      function void compare_field(input string name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(input rc_channels_type got);
         rc_channels_type want;
         if (pending_frames.size() == 0) begin
            $error("result beat with no frame pending");
            error_count++;
            return;
         end
         want = pending_frames.pop_front();
         compare_field("stick_ch0", want.ch0, got.ch0);
         compare_field("stick_ch1", want.ch1, got.ch1);
         compare_field("stick_ch2", want.ch2, got.ch2);
         compare_field("stick_ch3", want.ch3, got.ch3);
         compare_field("switch_a", want.sw_a, got.sw_a);
         compare_field("switch_b", want.sw_b, got.sw_b);
         compare_field("wheel_ch6", want.ch6, got.ch6);
      endfunction
   endclass

   logic clock;
   logic reset;

   rcfd_req_if req_bus ();
   rcfd_rsp_if rsp_bus ();
   rcfd_csr_if csr_bus ();

   rc_frame_channel_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   channel_scoreboard frames = new();

   bit          hold_req;
   bit          hold_active;
   int          burst_left;
   int unsigned stored_bytes;
   int unsigned cur_gap;
   logic [31:0] tnow;
   int unsigned idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         frames.check_result({rsp_bus.stick_ch0, rsp_bus.stick_ch1, rsp_bus.stick_ch2,
                              rsp_bus.stick_ch3, rsp_bus.switch_a, rsp_bus.switch_b,
                              rsp_bus.wheel_ch6});
      end
   end

   // Watchdog: count cycles without any beat on any channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver: random stall patterns, each held for a random span; long hold on request
   initial begin
      int mode;
      int span;
      int tick;
      rsp_bus.ready = 1'b0;
      mode = 0;
      span = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_active = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_active = 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(32, 256);
            end
            span--;
            tick++;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (tick % 4 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Offer one byte; enter and leave on a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
      if (burst_left == 0) begin
         if (!hold_active && $urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid           <= 1'b1;
      req_bus.rx_byte         <= b;
      req_bus.arrival_time_us <= t;
      do @(posedge clock); while (!req_bus.ready);
      if (frames.note_byte(b, t)) stored_bytes++;
      @(negedge clock);
   endtask

   task automatic write_gap(input logic [15:0] v);
      csr_bus.valid        <= 1'b1;
      csr_bus.frame_gap_us <= v;
      do @(posedge clock); while (!csr_bus.ready);
      frames.set_gap(v);
      cur_gap = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Hold input until every pending frame is out, then let the pipeline settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (frames.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte(input int fill_mode);
      case (fill_mode)
         1: return 8'h00;
         2: return 8'hFF;
         3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: begin
            case ($urandom_range(0, 7))
               0: return 8'h00;
               1: return 8'hFF;
               default: return 8'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] start_delta();
      logic [31:0] d;
      case ($urandom_range(0, 3))
         0: d = cur_gap;
         1: d = cur_gap + $urandom_range(0, 5000);
         2: begin
            d = $urandom;
            if (d < cur_gap) d = cur_gap;
         end
         default: d = cur_gap + $urandom_range(0, 200);
      endcase
      return d;
   endfunction

   function automatic logic [31:0] inner_delta();
      if (cur_gap == 0) return 32'd0;
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return cur_gap - 1;
         default: return $urandom_range(0, cur_gap - 1);
      endcase
   endfunction

   // Mostly full frames, some cut short by a new gap, some stray bytes.
   task automatic send_episode();
      int kind;
      int n_bytes;
      int fill_mode;
      int extra;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         repeat ($urandom_range(1, 5)) begin
            tnow += $urandom;
            send_byte(pick_byte(0), tnow);
         end
      end else begin
         n_bytes = (kind < 85) ? FRAME_LENGTH : $urandom_range(1, FRAME_LENGTH - 1);
         fill_mode = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         tnow += start_delta();
         send_byte(pick_byte(fill_mode), tnow);
         for (int i = 1; i < n_bytes; i++) begin
            tnow += inner_delta();
            send_byte(pick_byte(fill_mode), tnow);
         end
         extra = (n_bytes == FRAME_LENGTH && $urandom_range(0, 3) == 0) ?
                 $urandom_range(1, 3) : 0;
         repeat (extra) begin
            tnow += inner_delta();
            send_byte(pick_byte(0), tnow);
         end
      end
   endtask

   initial begin
      logic [15:0] gap_plan[8];
      int unsigned phase_start;
      int unsigned quota;
      bit          hold_done;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.rx_byte         = '0;
      req_bus.arrival_time_us = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.frame_gap_us    = '0;
      hold_req                = 1'b0;
      hold_active             = 1'b0;
      burst_left              = 0;
      stored_bytes            = 0;
      cur_gap                 = FRAME_GAP_RESET;
      hold_done               = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset gap: first byte measured from time zero and too early, so drop it
      send_byte(8'h00, 32'd50);
      // Frame on the exact gap, all-ones payload, inner spacing one short of a gap
      tnow = 32'd150;
      send_byte(8'hFF, tnow);
      repeat (FRAME_LENGTH - 1) begin
         tnow += 32'd99;
         send_byte(8'hFF, tnow);
      end
      // Ignore bytes past a full frame
      send_byte(8'h00, tnow);
      tnow += 32'd99;
      send_byte(8'hA5, tnow);
      // Timestamp extremes across the wrap
      send_byte(8'h00, 32'hFFFF_FFFF);
      send_byte(8'h00, 32'h0000_0000);
      tnow = 32'h0000_0000;

      gap_plan[0] = 16'd1;
      gap_plan[1] = 16'hFFFF;
      gap_plan[2] = 16'h5555;
      gap_plan[3] = 16'hAAAA;
      gap_plan[4] = 16'd0;
      gap_plan[5] = 16'($urandom_range(1, 65535));
      gap_plan[6] = 16'($urandom_range(1, 2000));
      gap_plan[7] = FRAME_GAP_RESET;

      foreach (gap_plan[p]) begin
         drain_results();
         write_gap(gap_plan[p]);
         // A zero gap restarts on every byte and never completes a frame: keep it short
         quota = (gap_plan[p] == 0) ? 40 : PHASE_BYTES;
         phase_start = stored_bytes;
         while (stored_bytes - phase_start < quota) begin
            if (p == 2 && !hold_done && stored_bytes - phase_start >= 40) begin
               hold_req = 1'b1;
               hold_done = 1'b1;
            end
            send_episode();
         end
      end

      drain_results();
      if (frames.error_count == 0 && frames.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
src/rcfd_pkg.sv
src/rcfd_if.sv
src/rcfd_frame_collect.sv
src/rcfd_scale.sv
src/rc_frame_channel_decoder_core.sv
src/rcfd_checker.sv
test/tb_rc_frame_channel_decoder_core.sv
